/* src/swtm_pkg.sv */
package swtm_pkg;

    // Sizes of the window and of one sample
    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int SLOT_W      = $clog2(WINDOW_MAX);
    localparam int LEN_W       = 7;
    localparam int TRIM_W      = 5;
    localparam int CFG_W       = 7;
    localparam int IDX_W       = 2;
    localparam int MEAN_W      = 16;
    localparam int SUM_W       = SAMPLE_BITS + SLOT_W;
    localparam int CNT_W       = $clog2(SUM_W + 1);

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [IDX_W-1:0] REG_TRIM_COUNT = 2'd1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                 step;
        logic                 full;
        logic                 clear;
        logic                 load;
        logic                 shift;
        sample_t              old_val;
        sample_t              new_val;
        logic [TRIM_W-1:0]    lo;
        logic [LEN_W-1:0]     hi;
    } cell_ctrl_t;

    // What one cell shows to its neighbors
    typedef struct packed {
        sample_t val;
        logic    valid;
        logic    below_old;
        logic    le_new;
        logic    in_rest;
        sample_t drain;
    } cell_link_t;

endpackage

/* src/sliding_window_trimmed_mean_core.sv */
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+------------------------------
// sample    | sample_valid / sample_ready   | sample[15:0]
// result    | result_valid / result_ready   | ready_res, trimmed_mean[15:0]
// config    | wr_en (no wait)               | reg_index[1:0], wr_data[6:0]
//
// One sample at a time. A sample whose window is full and whose trim leaves a
// middle part goes through one ring read, one cell update, one load, a drain of
// all entries of the effective window length through the cell chain and the
// bit-serial divider, then output. Other samples go through read, update, output.
// Reset empties the window and sets window_len 8, trim_count 1.
// A waiting result holds the next sample only once its own result is ready.
module sliding_window_trimmed_mean_core import swtm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  sample_t           sample,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              ready_res,
    output logic [MEAN_W-1:0] trimmed_mean,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  reg_index,
    input  logic [CFG_W-1:0]  wr_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [LEN_W-1:0]  win_len_reg;
    logic [TRIM_W-1:0] trim_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [LEN_W-1:0]  fill_reg;
    logic [LEN_W-1:0]  fill_next;
    sample_t           sample_reg;
    logic              hit_reg;
    logic              hit_next;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  cnt_next;
    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  acc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              res_ready_reg;
    logic [MEAN_W-1:0] res_mean_reg;

    logic              sample_fire;
    logic              cfg_clear;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  trim2;
    logic              trim_ok;
    logic              full;
    logic [LEN_W-1:0]  fill_after;
    logic              out_load;
    sample_t           ram_rdata;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  quotient;
    cell_ctrl_t        ctrl;
    cell_link_t        links [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] valid_vec;

    assign sample_fire = sample_valid && sample_ready;
    assign sample_ready = (state_reg == ST_IDLE);
    assign cfg_clear   = wr_en && ((reg_index == REG_WINDOW_LEN) ||
                                   (reg_index == REG_TRIM_COUNT));

    // Clamp the window length to the chain length, at least one
    always_comb
    begin
        if (win_len_reg > LEN_W'(WINDOW_MAX))
        begin
            eff_len = LEN_W'(WINDOW_MAX);
        end
        else if (win_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else
        begin
            eff_len = win_len_reg;
        end
    end

    assign trim2      = LEN_W'({trim_reg, 1'b0});
    assign trim_ok    = trim2 < eff_len;
    assign full       = (fill_reg == eff_len);
    assign fill_after = full ? fill_reg : fill_reg + 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= LEN_W'(8);
            trim_reg    <= TRIM_W'(1);
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_WINDOW_LEN: win_len_reg <= wr_data[LEN_W-1:0];
                REG_TRIM_COUNT: trim_reg    <= wr_data[TRIM_W-1:0];
                default:        ;
            endcase
        end
    end

    // Arrival order ring: read the leaving sample at accept, write in update
    swtm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == ST_UPD),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .re    (sample_fire),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Broadcast control to the sorted chain
    always_comb
    begin
        ctrl.step    = (state_reg == ST_UPD);
        ctrl.full    = full;
        ctrl.clear   = cfg_clear;
        ctrl.load    = (state_reg == ST_LOAD);
        ctrl.shift   = (state_reg == ST_DRAIN);
        ctrl.old_val = ram_rdata;
        ctrl.new_val = sample_reg;
        ctrl.lo      = trim_reg;
        ctrl.hi      = eff_len - LEN_W'(trim_reg);
    end

    // Sorted cell chain, cell zero holds the smallest sample
    localparam cell_link_t LEFT_EDGE  = '{val: '0, valid: 1'b1, below_old: 1'b0,
                                          le_new: 1'b0, in_rest: 1'b1, drain: '0};
    localparam cell_link_t RIGHT_EDGE = '{val: '0, valid: 1'b0, below_old: 1'b0,
                                          le_new: 1'b0, in_rest: 1'b0, drain: '0};

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        cell_link_t left_in;
        cell_link_t right_in;

        if (i == 0)
        begin : g_first
            assign left_in = LEFT_EDGE;
        end
        else
        begin : g_mid_l
            assign left_in = links[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign right_in = RIGHT_EDGE;
        end
        else
        begin : g_mid_r
            assign right_in = links[i+1];
        end

        swtm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .idx   (SLOT_W'(i)),
            .left  (left_in),
            .right (right_in),
            .link  (links[i])
        );

        assign valid_vec[i] = links[i].valid;
    end

    // Divide the middle sum by the middle count
    swtm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_next),
        .divisor  (eff_len - trim2),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || result_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        hit_next   = hit_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_fire)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                fill_next = fill_after;
                slot_next = ((LEN_W'(slot_reg) + 1'b1) >= eff_len) ? '0 : slot_reg + 1'b1;
                hit_next  = (fill_after == eff_len) && trim_ok;
                state_next = ((fill_after == eff_len) && trim_ok) ? ST_LOAD : ST_OUT;
            end
            ST_LOAD:
            begin
                cnt_next   = eff_len;
                acc_next   = '0;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                acc_next = acc_reg + SUM_W'(links[0].drain);
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == LEN_W'(1))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A write to either configuration register empties the window
        if (cfg_clear)
        begin
            slot_next = '0;
            fill_next = '0;
        end
    end

    assign out_valid_next = (out_valid_reg && !result_ready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            hit_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            hit_reg       <= hit_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the sample, sum and result transaction
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            sample_reg <= sample;
        end
        acc_reg <= acc_next;
        if (out_load)
        begin
            res_ready_reg <= hit_reg;
            res_mean_reg  <= hit_reg ? quotient[MEAN_W-1:0] : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign ready_res    = res_ready_reg;
    assign trimmed_mean = res_mean_reg;

    // Occupied cells track the fill count
    a_fill_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_reg))
        else $error("sorted chain occupancy differs from fill count");

    // Fill count never passes the window length
    a_fill_len: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= eff_len)
        else $error("fill count above window length");

    // Divider finishes only while the sequencer waits for it
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

endmodule

/* src/swtm_ram.sv */
module swtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/swtm_cell.sv */
module swtm_cell import swtm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [SLOT_W-1:0] idx,
    input  cell_link_t        left,
    input  cell_link_t        right,
    output cell_link_t        link
);

    sample_t val_reg;
    sample_t val_next;
    logic    valid_reg;
    logic    valid_next;
    sample_t drain_reg;
    sample_t drain_next;

    logic    below_old;
    logic    le_new;
    logic    in_rest;
    logic    at_new;
    logic    in_middle;

    // Local compares against the leaving and the arriving sample
    assign below_old = valid_reg && (!ctrl.full || (val_reg < ctrl.old_val));
    assign le_new    = valid_reg && (val_reg <= ctrl.new_val);

    // Slot still holds a kept sample that sorts at or below the new one
    assign in_rest   = below_old ? le_new : right.le_new;
    assign at_new    = !in_rest && left.in_rest;

    assign in_middle = (idx >= SLOT_W'(ctrl.lo)) && (LEN_W'(idx) < ctrl.hi);

    // Pick own, right or left value, or take the new sample
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.step)
        begin
            if (in_rest)
            begin
                val_next = below_old ? val_reg : right.val;
            end
            else if (at_new)
            begin
                val_next = ctrl.new_val;
            end
            else
            begin
                val_next = left.below_old ? left.val : val_reg;
            end
        end
    end

    // Grow the occupied prefix by one while the window fills; clear empties it
    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.step && !ctrl.full)
        begin
            valid_next = valid_reg | left.valid;
        end
    end

    // Load the middle part, then shift it toward cell zero
    always_comb
    begin
        drain_next = drain_reg;
        if (ctrl.load)
        begin
            drain_next = in_middle ? val_reg : '0;
        end
        else if (ctrl.shift)
        begin
            drain_next = right.drain;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        drain_reg <= drain_next;
    end

    assign link.val       = val_reg;
    assign link.valid     = valid_reg;
    assign link.below_old = below_old;
    assign link.le_new    = le_new;
    assign link.in_rest   = in_rest;
    assign link.drain     = drain_reg;

endmodule

/* src/swtm_div.sv */
module swtm_div import swtm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [LEN_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic [SUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] quo_next;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic [LEN_W-1:0] div_reg;
    logic [LEN_W-1:0] div_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;

    logic [LEN_W:0]   rem_sh;
    logic             fits;

    // One quotient bit per cycle, restoring
    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign fits   = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? LEN_W'(rem_sh - {1'b0, div_reg}) : LEN_W'(rem_sh);
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import swtm_pkg::*;

    // Indexes past the register list; writes to them must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic              ready_res;
        logic [MEAN_W-1:0] trimmed_mean;
    } mean_result_t;

    // Window model: arrival ring plus sorted copy, and the means still owed
    class trimmed_mean_tracker;
        int unsigned  win_len;
        int unsigned  trim;
        sample_t      arrivals[WINDOW_MAX];
        sample_t      ordered[WINDOW_MAX];
        int unsigned  slot;
        int unsigned  held;
        mean_result_t expected_means[$];
        int unsigned  mismatches;
        int unsigned  full_means;
        int unsigned  samples_taken;

        function new();
            win_len       = 8;
            trim          = 1;
            slot          = 0;
            held          = 0;
            mismatches    = 0;
            full_means    = 0;
            samples_taken = 0;
        endfunction

        // Apply a register write; any listed register empties the window
        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_WINDOW_LEN) begin
                win_len = data;
                slot    = 0;
                held    = 0;
            end else if (idx == REG_TRIM_COUNT) begin
                trim = data[TRIM_W-1:0];
                slot = 0;
                held = 0;
            end
        endfunction

        function int unsigned span();
            if (win_len > WINDOW_MAX)
                return WINDOW_MAX;
            if (win_len < 1)
                return 1;
            return win_len;
        endfunction

        // Note an accepted sample and queue the mean it must produce
        function void take_sample(sample_t s);
            int unsigned       n;
            int unsigned       i;
            int unsigned       j;
            longint unsigned   acc;
            mean_result_t      rec;
            n = span();
            if (slot >= n)
                slot = 0;
            // Drop one sorted entry equal to the sample leaving the window
            if (held >= n) begin
                for (i = 0; i < held; i++) begin
                    if (ordered[i] == arrivals[slot]) begin
                        for (j = i; j + 1 < held; j++)
                            ordered[j] = ordered[j + 1];
                        held--;
                        break;
                    end
                end
            end
            // Insert after any equal values
            if (held < WINDOW_MAX) begin
                i = 0;
                while (i < held && ordered[i] <= s)
                    i++;
                for (j = held; j > i; j--)
                    ordered[j] = ordered[j - 1];
                ordered[i] = s;
                held++;
            end
            arrivals[slot] = s;
            slot = (slot + 1 >= n) ? 0 : slot + 1;
            rec.ready_res    = 1'b0;
            rec.trimmed_mean = '0;
            if (held == n && 2 * trim < n) begin
                acc = 0;
                for (i = trim; i < n - trim; i++)
                    acc += ordered[i];
                rec.ready_res    = 1'b1;
                rec.trimmed_mean = MEAN_W'(acc / (n - 2 * trim));
                full_means++;
            end
            expected_means.push_back(rec);
            samples_taken++;
        endfunction

        // Compare one accepted result with the oldest owed mean
        function void match_result(logic rdy, logic [MEAN_W-1:0] mean);
            mean_result_t want;
            if (expected_means.size() == 0) begin
                $error("result transaction with no sample pending: ready_res %0d mean %0d",
                       rdy, mean);
                mismatches++;
                return;
            end
            want = expected_means.pop_front();
            if (rdy !== want.ready_res) begin
                $error("ready_res: expected %0d, got %0d", want.ready_res, rdy);
                mismatches++;
            end
            if (mean !== want.trimmed_mean) begin
                $error("trimmed_mean: expected %0d, got %0d", want.trimmed_mean, mean);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_means.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_ready;
    logic [15:0]       sample = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic              ready_res;
    logic [MEAN_W-1:0] trimmed_mean;
    logic              wr_en = 1'b0;
    logic [IDX_W-1:0]  reg_index = '0;
    logic [CFG_W-1:0]  wr_data = '0;

    trimmed_mean_tracker tracker;
    int unsigned send_gap_max = 12;
    int unsigned stall_max = 12;
    int unsigned phases = 0;

    sliding_window_trimmed_mean_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .ready_res    (ready_res),
        .trimmed_mean (trimmed_mean),
        .wr_en        (wr_en),
        .reg_index    (reg_index),
        .wr_data      (wr_data)
    );

    always #5 clk = ~clk;

    // Drop valid and hold until every owed mean has come back
    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        wr_en     <= 1'b1;
        reg_index <= idx;
        wr_data   <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    // Reprogram both registers in random order once the block is idle
    task automatic set_window(int unsigned len_raw, int unsigned trim_raw);
        logic [CFG_W-1:0] tdata;
        tdata = CFG_W'(trim_raw) | (CFG_W'($urandom_range(0, 3)) << TRIM_W);
        wait_drained();
        if ($urandom_range(0, 1)) begin
            write_reg(REG_WINDOW_LEN, CFG_W'(len_raw));
            write_reg(REG_TRIM_COUNT, tdata);
        end else begin
            write_reg(REG_TRIM_COUNT, tdata);
            write_reg(REG_WINDOW_LEN, CFG_W'(len_raw));
        end
        wr_en <= 1'b0;
    endtask

    // Write both unused indexes while the window holds data
    task automatic poke_spares();
        wait_drained();
        write_reg(REG_SPARE_2, CFG_W'($urandom));
        write_reg(REG_SPARE_3, CFG_W'($urandom));
        wr_en <= 1'b0;
    endtask

    // Drive one sample transaction after a random gap
    task automatic send_sample(sample_t v);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= v;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        tracker.take_sample(v);
    endtask

    // Mix of full-range values, duplicates and both extremes
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0, 1, 2: return sample_t'($urandom);
            3, 4:    return sample_t'($urandom_range(0, 3));
            5:       return $urandom_range(0, 1) ? {SAMPLE_BITS{1'b1}} : sample_t'(0);
            6:       return sample_t'(16'hFFFF - $urandom_range(0, 3));
            default: return sample_t'($urandom_range(100, 103));
        endcase
    endfunction

    task automatic run_phase(int unsigned len_raw, int unsigned trim_raw,
                             int unsigned count);
        int unsigned k;
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
        stall_max    = ($urandom_range(0, 3) == 0) ? 0 : 12;
        set_window(len_raw, trim_raw);
        for (k = 0; k < count; k++) begin
            if (k == count / 2 && $urandom_range(0, 3) == 0)
                poke_spares();
            send_sample(pick_sample());
        end
        phases++;
    endtask

    // Accept results with a random stall drawn per transaction
    initial begin
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever begin
            hold = $urandom_range(0, stall_max);
            if (hold == 0) begin
                result_ready <= 1'b1;
            end else begin
                result_ready <= 1'b0;
                @(posedge clk);
                while (!result_valid)
                    @(posedge clk);
                repeat (hold - 1) @(posedge clk);
                result_ready <= 1'b1;
            end
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            tracker.match_result(ready_res, trimmed_mean);
        end
    end

    initial begin
        int unsigned random_sent;
        int unsigned len_raw;
        int unsigned trim_raw;
        int unsigned eff;
        int unsigned count;
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: extremes and repeated values leaving the window
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0007);
        send_sample(16'h0007);
        phases++;

        // Shortest useful window, then unused indexes must keep it full
        set_window(3, 1);
        send_sample(16'd5);
        send_sample(16'd5);
        send_sample(16'd9);
        send_sample(16'hFFFF);
        poke_spares();
        send_sample(16'd0);
        send_sample(16'd3);
        phases++;

        // Trim leaves no middle part
        set_window(4, 2);
        send_sample(16'd100);
        send_sample(16'd200);
        send_sample(16'd300);
        send_sample(16'd400);
        phases++;

        // Zero length clamps to one, trim of zero
        set_window(0, 0);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        phases++;

        // Corner settings with random content
        random_sent = 0;
        run_phase(64, 31, 74);
        run_phase(127, 0, 74);
        run_phase(1, 1, 8);
        run_phase(2, 0, 12);
        run_phase(2, 1, 8);
        run_phase(90, 5, 70);
        random_sent = 74 + 74 + 8 + 12 + 8 + 70;

        // Random settings, mostly short windows
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                len_raw = $urandom_range(0, 127);
            else
                len_raw = $urandom_range(3, 20);
            eff = (len_raw > WINDOW_MAX) ? WINDOW_MAX : ((len_raw < 1) ? 1 : len_raw);
            if ($urandom_range(0, 4) == 0)
                trim_raw = $urandom_range(0, 31);
            else
                trim_raw = $urandom_range(0, (eff - 1) / 2);
            count = eff + $urandom_range(5, 40);
            run_phase(len_raw, trim_raw, count);
            random_sent += count;
        end

        // Let the last results land, then allow for anything stray
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples across %0d window settings; %0d results carried a mean.",
                 tracker.samples_taken, phases, tracker.full_means);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("sliding_window_trimmed_mean_core: match");
        end else begin
            $display("sliding_window_trimmed_mean_core: mismatch");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("sliding_window_trimmed_mean_core: mismatch");
        $finish;
    end

endmodule

/* files.f */
src/swtm_pkg.sv
src/swtm_ram.sv
src/swtm_cell.sv
src/swtm_div.sv
src/sliding_window_trimmed_mean_core.sv
tb/tb.sv
